FILE: hw/rtl/smrb_pkg.sv
// Shared types and constants for the saturating mix ring buffer.
package smrb_pkg;

  localparam int unsigned POS_W    = 32;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LAG_W    = 10;
  localparam int unsigned OP_W     = 2;

  localparam logic [LAG_W-1:0] READ_LAG_RESET = 10'd2;

  // Front-to-back item queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [OP_W-1:0] {
    OP_MIX   = 2'd0,
    OP_READ  = 2'd1,
    OP_TRACK = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // What the back end does with an item
  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,
    CMD_MIX  = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           tracked;
    logic [POS_W-1:0]           lagged_pos;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_t;

endpackage

FILE: hw/rtl/smrb_front.sv
// Front end: accepts items, tracks playback position, decides burst acceptance.
module smrb_front #(
  parameter int unsigned ADDR_W = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [smrb_pkg::OP_W-1:0]         opcode,
  input  logic [smrb_pkg::POS_W-1:0]        base_position,
  input  logic [smrb_pkg::IDX_W-1:0]        sample_index,
  input  logic signed [smrb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                              last_sample,
  input  logic [smrb_pkg::IDX_W-1:0]        playback_offset,
  input  logic                              cfg_we,
  input  logic [smrb_pkg::LAG_W-1:0]        cfg_wdata,
  output smrb_pkg::cmd_t                    cmd,
  output logic [ADDR_W-1:0]                 slot
);
  import smrb_pkg::*;

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    burst_r, burst_nxt;
  logic [LAG_W-1:0]        lag_r;
  opcode_t                 op;
  cmd_kind_t               kind;
  logic [POS_W-1:0]        addr_sum;
  logic [POS_W-1:0]        off_ext;
  logic [ADDR_W-1:0]       off;
  logic [ADDR_W-1:0]       low;
  logic                    wrap;
  logic [POS_W-ADDR_W-1:0] wrap_hi;
  logic                    first_ok;

  assign op = opcode_t'(opcode);

  // Slot address: low bits of base plus index
  assign addr_sum = base_position + POS_W'(sample_index);
  assign slot     = addr_sum[ADDR_W-1:0];

  // Position extension: keep wrap count, step it when the offset goes backwards
  assign off_ext = POS_W'(playback_offset);
  assign off     = off_ext[ADDR_W-1:0];
  assign low     = pos_r[ADDR_W-1:0];
  assign wrap    = (off < low);
  assign wrap_hi = pos_r[POS_W-1:ADDR_W] + (POS_W-ADDR_W)'(wrap);

  // Stale check on the first sample, latched flag otherwise
  assign first_ok = (sample_index == '0) ? (base_position >= pos_r) : burst_r;

  // Item decode
  always_comb begin
    pos_nxt   = pos_r;
    burst_nxt = burst_r;
    kind      = CMD_PASS;
    unique case (op)
      OP_MIX: begin
        kind      = first_ok ? CMD_MIX : CMD_PASS;
        burst_nxt = last_sample ? 1'b0 : first_ok;
      end
      OP_READ: begin
        kind = CMD_READ;
      end
      OP_TRACK: begin
        pos_nxt = {wrap_hi, off};
      end
      OP_NONE: begin
        kind = CMD_PASS;
      end
      default: begin
        kind = CMD_PASS;
      end
    endcase
  end

  assign cmd.kind       = kind;
  assign cmd.sample     = sample_in;
  assign cmd.tracked    = pos_nxt;
  assign cmd.lagged_pos = pos_nxt - POS_W'(lag_r);

  // Position, burst flag and lag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      burst_r <= 1'b0;
      lag_r   <= READ_LAG_RESET;
    end else begin
      if (accept) begin
        pos_r   <= pos_nxt;
        burst_r <= burst_nxt;
      end
      if (cfg_we) begin
        lag_r <= cfg_wdata;
      end
    end
  end

endmodule

FILE: hw/rtl/smrb_queue.sv
// Short in-order queue of decoded items between front and back ends.
module smrb_queue #(
  parameter int unsigned SLOT_W = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  smrb_pkg::cmd_t      push_cmd,
  input  logic [SLOT_W-1:0]   push_slot,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output smrb_pkg::cmd_t      head_cmd,
  output logic [SLOT_W-1:0]   head_slot
);
  import smrb_pkg::*;

  cmd_t              cmd_mem  [QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_cmd  = cmd_mem[rd_ptr_r];
  assign head_slot = slot_mem[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr_r]  <= push_cmd;
      slot_mem[wr_ptr_r] <= push_slot;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/smrb_back.sv
// Back end: sample memory, clearing pass, saturating read-modify-write, results.
module smrb_back #(
  parameter int unsigned BUFFER_DEPTH = 1024,
  parameter int unsigned ADDR_W       = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 empty,
  input  smrb_pkg::cmd_t                       head_cmd,
  input  logic [ADDR_W-1:0]                    head_slot,
  output logic                                 pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  output logic signed [smrb_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic [smrb_pkg::POS_W-1:0]           out_tracked_position,
  output logic [smrb_pkg::POS_W-1:0]           out_read_position,
  output logic                                 out_accepted,
  output logic                                 out_saturated
);
  import smrb_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [BUFFER_DEPTH];

  bk_state_t                  state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_cnt_r;
  cmd_t                       cmd_r;
  logic [ADDR_W-1:0]          slot_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       fwd_r;
  logic signed [SAMPLE_W-1:0] fwd_data_r;

  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W-1:0] mix_val;
  logic                       mix_sat;
  logic                       exec;
  logic                       exec_we;
  logic signed [SAMPLE_W-1:0] exec_wdata;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [POS_W-1:0]           out_tracked_r;
  logic [POS_W-1:0]           out_read_r;
  logic                       out_acc_r;
  logic                       out_sat_r;

  assign exec     = (state_r == BK_EXEC);
  assign clearing = (state_r == BK_CLEAR);

  // Slot value: forwarded from the previous write when it hit the same slot
  assign cur = fwd_r ? fwd_data_r : rd_data_r;

  // Saturating mix
  assign sum = {cur[SAMPLE_W-1], cur} + {cmd_r.sample[SAMPLE_W-1], cmd_r.sample};
  always_comb begin
    mix_sat = (sum[SAMPLE_W] != sum[SAMPLE_W-1]);
    if (!mix_sat) begin
      mix_val = sum[SAMPLE_W-1:0];
    end else if (sum[SAMPLE_W]) begin
      mix_val = SAMPLE_MIN;
    end else begin
      mix_val = SAMPLE_MAX;
    end
  end

  assign exec_we    = exec && (cmd_r.kind != CMD_PASS);
  assign exec_wdata = (cmd_r.kind == CMD_MIX) ? mix_val : '0;

  // Memory write port: clearing pass or item write-back
  assign mem_we    = clearing || exec_we;
  assign mem_waddr = clearing ? clr_cnt_r : slot_r;
  assign mem_wdata = clearing ? '0 : exec_wdata;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(BUFFER_DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        pop = !empty;
        if (!empty) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        pop       = !empty;
        state_nxt = empty ? BK_IDLE : BK_EXEC;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Sample memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_data_r <= mem[head_slot];
    end
  end

  // Item latch and write forwarding
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r      <= head_cmd;
      slot_r     <= head_slot;
      fwd_r      <= exec_we && (slot_r == head_slot);
      fwd_data_r <= exec_wdata;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_sample_r  <= (cmd_r.kind == CMD_READ) ? cur : '0;
      out_tracked_r <= cmd_r.tracked;
      out_read_r    <= cmd_r.lagged_pos;
      out_acc_r     <= (cmd_r.kind == CMD_MIX);
      out_sat_r     <= (cmd_r.kind == CMD_MIX) && mix_sat;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sample_out       = out_sample_r;
  assign out_tracked_position = out_tracked_r;
  assign out_read_position    = out_read_r;
  assign out_accepted         = out_acc_r;
  assign out_saturated        = out_sat_r;

endmodule

FILE: hw/rtl/saturating_mix_ring_buffer.sv
// Top level of the saturating mix ring buffer.
//
// Ring of BUFFER_DEPTH signed 16-bit audio slots (BUFFER_DEPTH a power of two).
// Input channel: an item is taken at a clock edge with start high and busy low.
// Opcode 0 mixes in_sample_in into slot (base + index) with int16 clipping,
// the whole burst being dropped when its first sample lies behind the tracked
// playback position; opcode 1 reads a slot and clears it; opcode 2 advances
// the 32-bit playback position from a slot offset. cfg_we/cfg_wdata load the
// read lag (reset value 2); the user must write it only while the block is idle,
// as the block does not enforce this. Every item gives exactly one result,
// shown for one cycle with out_valid high, after passing the queue, the
// back-end item latch and the result registers. The receiver cannot stall.
// Throughput is one item per cycle: the back end reads the memory and writes
// back in the next cycle, overlapped, with forwarding between items that hit
// the same slot. The back end drains the 4-entry queue one item per cycle, so
// the queue never fills and busy stays low after clearing. After reset the
// memory is zeroed one slot a cycle, with busy high until every slot is clear.
module saturating_mix_ring_buffer #(
  parameter int unsigned BUFFER_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [smrb_pkg::OP_W-1:0]            in_opcode,
  input  logic [smrb_pkg::POS_W-1:0]           in_base_position,
  input  logic [smrb_pkg::IDX_W-1:0]           in_sample_index,
  input  logic signed [smrb_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                 in_last_sample,
  input  logic [smrb_pkg::IDX_W-1:0]           in_playback_offset,
  input  logic                                 cfg_we,
  input  logic [smrb_pkg::LAG_W-1:0]           cfg_wdata,
  output logic                                 out_valid,
  output logic signed [smrb_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic [smrb_pkg::POS_W-1:0]           out_tracked_position,
  output logic [smrb_pkg::POS_W-1:0]           out_read_position,
  output logic                                 out_accepted,
  output logic                                 out_saturated
);
  import smrb_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  logic              accept;
  cmd_t              front_cmd;
  logic [ADDR_W-1:0] front_slot;
  cmd_t              head_cmd;
  logic [ADDR_W-1:0] head_slot;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic              clearing;

  assign busy   = clearing || q_full;
  assign accept = start && !busy;

  smrb_front #(
    .ADDR_W (ADDR_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .opcode          (in_opcode),
    .base_position   (in_base_position),
    .sample_index    (in_sample_index),
    .sample_in       (in_sample_in),
    .last_sample     (in_last_sample),
    .playback_offset (in_playback_offset),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (front_cmd),
    .slot            (front_slot)
  );

  smrb_queue #(
    .SLOT_W (ADDR_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cmd  (front_cmd),
    .push_slot (front_slot),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_cmd  (head_cmd),
    .head_slot (head_slot)
  );

  smrb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .empty                (q_empty),
    .head_cmd             (head_cmd),
    .head_slot            (head_slot),
    .pop                  (q_pop),
    .clearing             (clearing),
    .out_valid            (out_valid),
    .out_sample_out       (out_sample_out),
    .out_tracked_position (out_tracked_position),
    .out_read_position    (out_read_position),
    .out_accepted         (out_accepted),
    .out_saturated        (out_saturated)
  );

endmodule

FILE: hw/rtl/smrb_checker.sv
// Port-level checks for the saturating mix ring buffer, bound to the top level.
module smrb_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_accepted,
  input logic out_saturated
);

  // Reset starts the clearing pass, so no item is taken right after it
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // Every accepted item shows its result on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  // No result without a matching item accepted before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching item");

  // Clipping is only reported on an applied write
  a_sat_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_accepted)
    else $error("saturated flag on a write that was not applied");

endmodule

bind saturating_mix_ring_buffer smrb_checker u_smrb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_accepted  (out_accepted),
  .out_saturated (out_saturated)
);
